// File: sv/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

   localparam int unsigned SqCells = 25;
   localparam int unsigned SqSide  = 5;
   localparam int unsigned Alpha   = 26;

   localparam logic [4:0] LetI = 5'd8;
   localparam logic [4:0] LetJ = 5'd9;
   localparam logic [4:0] LetX = 5'd23;

   localparam logic [7:0] LetterA = 8'h61;

   typedef enum logic [1:0] {
      KIND_KEY_CHAR  = 2'd0,
      KIND_KEY_END   = 2'd1,
      KIND_TEXT_CHAR = 2'd2,
      KIND_TEXT_END  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_ODD_LENGTH = 2'd1,
      STAT_NON_LETTER = 2'd2,
      STAT_NO_TABLE   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_LOOK_A,
      S_LOOK_B,
      S_CALC,
      S_RD1,
      S_OUT1,
      S_RD2,
      S_OUT2,
      S_ERR
   } state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [7:0] out_letter;
      status_type status;
      logic       last_of_pair;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [4:0] idx;
   } letter_info_type;

   // Write port shared by the square and the position table.
   typedef struct packed {
      logic       en;
      logic [4:0] slot;
      logic [4:0] letter;
   } ks_wr_type;

   typedef struct packed {
      logic       pos_en;
      logic [4:0] pos_addr;
      logic       sq_en;
      logic [4:0] sq_addr;
   } ks_rd_type;

   typedef struct packed {
      logic latch_a;
      logic calc;
   } pc_ctrl_type;

   function automatic letter_info_type letter_of(input logic [7:0] code);
      letter_info_type r;
      logic [7:0]      lc;
      r.valid = 1'b0;
      r.idx   = '0;
      lc      = code;
      if (code >= 8'h41 && code <= 8'h5A) begin
         lc = code + 8'h20;
      end
      if (lc >= LetterA && lc <= 8'h7A) begin
         r.valid = 1'b1;
         r.idx   = 5'(lc - LetterA);
         if (r.idx == LetJ) begin
            r.idx = LetI;
         end
      end
      return r;
   endfunction

   function automatic logic [2:0] cell_row(input logic [4:0] p);
      logic [2:0] r;
      if (p >= 5'd20) begin
         r = 3'd4;
      end else if (p >= 5'd15) begin
         r = 3'd3;
      end else if (p >= 5'd10) begin
         r = 3'd2;
      end else if (p >= 5'd5) begin
         r = 3'd1;
      end else begin
         r = 3'd0;
      end
      return r;
   endfunction

   function automatic logic [2:0] cell_col(input logic [4:0] p);
      logic [2:0] r;
      r = cell_row(p);
      return 3'(p - {r, 2'b00} - {2'b00, r});
   endfunction

   function automatic logic [4:0] cell_of(input logic [2:0] row, input logic [2:0] col);
      return {row, 2'b00} + {2'b00, row} + {2'b00, col};
   endfunction

   // One step around a row or column, forward or backward, modulo the side.
   function automatic logic [2:0] step_mod(input logic [2:0] c, input logic back);
      logic [3:0] t;
      t = {1'b0, c} + (back ? 4'(SqSide - 1) : 4'd1);
      if (t >= 4'(SqSide)) begin
         t = t - 4'(SqSide);
      end
      return t[2:0];
   endfunction

endpackage

`default_nettype wire

// File: sv/pfc_key_store.sv
`default_nettype none

module pfc_key_store (
   input  wire logic              clock,
   input  wire pfc_pkg::ks_wr_type wr,
   input  wire pfc_pkg::ks_rd_type rd,
   output logic [4:0]             pos_q,
   output logic [4:0]             sq_q
);
   import pfc_pkg::*;

   logic [4:0] square_mem [SqCells];
   logic [4:0] pos_mem    [Alpha];
   logic [4:0] pos_q_ff;
   logic [4:0] sq_q_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         square_mem[wr.slot] <= wr.letter;
         pos_mem[wr.letter]  <= wr.slot;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.pos_en) begin
         pos_q_ff <= pos_mem[rd.pos_addr];
      end
      if (rd.sq_en) begin
         sq_q_ff <= square_mem[rd.sq_addr];
      end
   end

   assign pos_q = pos_q_ff;
   assign sq_q  = sq_q_ff;

endmodule

`default_nettype wire

// File: sv/pfc_pair_calc.sv
`default_nettype none

module pfc_pair_calc (
   input  wire logic                 clock,
   input  wire pfc_pkg::pc_ctrl_type ctrl,
   input  wire logic                 mode,
   input  wire logic [4:0]           pos_q,
   output logic [4:0]                q1,
   output logic [4:0]                q2
);
   import pfc_pkg::*;

   logic [4:0] pa_ff;
   logic [4:0] q1_ff;
   logic [4:0] q2_ff;
   logic [4:0] q1_in;
   logic [4:0] q2_in;
   logic [2:0] r1, c1, r2, c2;

   always_comb begin
      r1 = cell_row(pa_ff);
      c1 = cell_col(pa_ff);
      r2 = cell_row(pos_q);
      c2 = cell_col(pos_q);
      if (r1 == r2) begin
         q1_in = cell_of(r1, step_mod(c1, mode));
         q2_in = cell_of(r2, step_mod(c2, mode));
      end else if (c1 == c2) begin
         q1_in = cell_of(step_mod(r1, mode), c1);
         q2_in = cell_of(step_mod(r2, mode), c2);
      end else begin
         // Rectangle: the letters trade columns.
         q1_in = cell_of(r1, c2);
         q2_in = cell_of(r2, c1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.latch_a) begin
         pa_ff <= pos_q;
      end
      if (ctrl.calc) begin
         q1_ff <= q1_in;
         q2_ff <= q2_in;
      end
   end

   assign q1 = q1_ff;
   assign q2 = q2_ff;

endmodule

`default_nettype wire

// File: sv/playfair_digraph_cipher.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_data (kind, char_code)
// rsp       out        rsp_valid/rsp_stall  rsp_data (out_letter, status, last_of_pair)
// csr       in         csr_we               csr_wdata (cipher_mode)
//
// One item at a time: req_stall is high whenever the sequencer is not idle.
// A keyword char is taken while idle; key end, before a table exists, walks the fill over every letter.
// A ciphered pair goes through two position-table reads, one pair calculation and two
// square reads, each through the one read port of its store, and can be held by rsp stall.
// An error beat sends one status response. Reset is synchronous and clears control state only.

module playfair_digraph_cipher (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire pfc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output pfc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic             csr_wdata
);
   import pfc_pkg::*;

   state_type   state_ff, state_in;
   logic        mode_ff;
   logic [Alpha-1:0] used_ff, used_in;
   logic [4:0]  fill_count_ff, fill_count_in;
   logic        table_ready_ff, table_ready_in;
   logic        pending_valid_ff, pending_valid_in;
   logic [4:0]  pending_letter_ff, pending_letter_in;
   logic [4:0]  fill_idx_ff, fill_idx_in;
   logic [4:0]  a_ff, a_in, b_ff, b_in;
   status_type  err_status_ff, err_status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic            acc;
   logic            out_free;
   letter_info_type lt;
   logic            pair_match;

   // Placement unit, shared by keyword chars and the key-end fill.
   logic       place_req;
   logic       clr;
   logic [4:0] place_letter;
   logic [4:0] base_fill;
   logic       used_bit;
   logic       do_place;

   ks_wr_type   ks_wr;
   ks_rd_type   ks_rd;
   pc_ctrl_type pc_ctrl;
   logic [4:0]  pos_q, sq_q, q1, q2;
   logic        rsp_load;

   assign acc        = req_valid && (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign lt         = letter_of(req_data.char_code);
   assign pair_match = !mode_ff && (pending_letter_ff == lt.idx);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               unique case (req_data.kind)
                  KIND_KEY_CHAR: state_in = S_IDLE;
                  KIND_KEY_END:  state_in = table_ready_ff ? S_IDLE : S_FILL;
                  KIND_TEXT_CHAR: begin
                     if (!table_ready_ff) begin
                        state_in = S_ERR;
                     end else if (!lt.valid) begin
                        state_in = mode_ff ? S_ERR : S_IDLE;
                     end else if (!pending_valid_ff) begin
                        state_in = S_IDLE;
                     end else begin
                        state_in = S_LOOK_A;
                     end
                  end
                  KIND_TEXT_END: begin
                     if (!table_ready_ff) begin
                        state_in = S_ERR;
                     end else if (!pending_valid_ff) begin
                        state_in = S_IDLE;
                     end else begin
                        state_in = mode_ff ? S_ERR : S_LOOK_A;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FILL:   state_in = (fill_idx_ff == 5'(Alpha - 1)) ? S_IDLE : S_FILL;
         S_LOOK_A: state_in = S_LOOK_B;
         S_LOOK_B: state_in = S_CALC;
         S_CALC:   state_in = S_RD1;
         S_RD1:    state_in = S_OUT1;
         S_OUT1:   state_in = out_free ? S_RD2 : S_OUT1;
         S_RD2:    state_in = S_OUT2;
         S_OUT2:   state_in = out_free ? S_IDLE : S_OUT2;
         S_ERR:    state_in = out_free ? S_IDLE : S_ERR;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall       = (state_ff != S_IDLE);
      ks_rd.pos_en    = (state_ff == S_LOOK_A) || (state_ff == S_LOOK_B);
      ks_rd.pos_addr  = (state_ff == S_LOOK_A) ? a_ff : b_ff;
      ks_rd.sq_en     = (state_ff == S_RD1) || (state_ff == S_RD2);
      ks_rd.sq_addr   = (state_ff == S_RD1) ? q1 : q2;
      pc_ctrl.latch_a = (state_ff == S_LOOK_B);
      pc_ctrl.calc    = (state_ff == S_CALC);
      rsp_load        = out_free &&
                        ((state_ff == S_OUT1) || (state_ff == S_OUT2) || (state_ff == S_ERR));
      rsp_data_in     = rsp_data_ff;
      if (state_ff == S_ERR) begin
         rsp_data_in.out_letter   = '0;
         rsp_data_in.status       = err_status_ff;
         rsp_data_in.last_of_pair = 1'b1;
      end else begin
         rsp_data_in.out_letter   = LetterA + {3'b000, sq_q};
         rsp_data_in.status       = STAT_OK;
         rsp_data_in.last_of_pair = (state_ff == S_OUT2);
      end
   end

   always_comb begin
      clr          = acc && (req_data.kind == KIND_KEY_CHAR) && table_ready_ff;
      place_req    = (acc && (req_data.kind == KIND_KEY_CHAR) && lt.valid) ||
                     ((state_ff == S_FILL) && (fill_idx_ff != LetJ));
      place_letter = (state_ff == S_FILL) ? fill_idx_ff : lt.idx;
      base_fill    = clr ? 5'd0 : fill_count_ff;
      used_bit     = clr ? 1'b0 : used_ff[place_letter];
      do_place     = place_req && !used_bit && (base_fill < 5'(SqCells));

      ks_wr.en     = do_place;
      ks_wr.slot   = base_fill;
      ks_wr.letter = place_letter;

      used_in        = clr ? '0 : used_ff;
      fill_count_in  = base_fill;
      table_ready_in = clr ? 1'b0 : table_ready_ff;
      if (do_place) begin
         used_in[place_letter] = 1'b1;
         fill_count_in         = base_fill + 5'd1;
      end
      if ((state_ff == S_FILL) && (fill_idx_ff == 5'(Alpha - 1))) begin
         table_ready_in = 1'b1;
      end
      fill_idx_in = (state_ff == S_FILL) ? fill_idx_ff + 5'd1 : 5'd0;
   end

   always_comb begin
      pending_valid_in  = pending_valid_ff;
      pending_letter_in = pending_letter_ff;
      a_in              = a_ff;
      b_in              = b_ff;
      err_status_in     = err_status_ff;
      if (acc) begin
         case (req_data.kind)
            KIND_KEY_CHAR: begin
               if (table_ready_ff) begin
                  pending_valid_in  = 1'b0;
                  pending_letter_in = '0;
               end
            end
            KIND_TEXT_CHAR: begin
               if (!table_ready_ff) begin
                  err_status_in = STAT_NO_TABLE;
               end else if (!lt.valid) begin
                  err_status_in = STAT_NON_LETTER;
               end else if (!pending_valid_ff) begin
                  pending_valid_in  = 1'b1;
                  pending_letter_in = lt.idx;
               end else if (pair_match) begin
                  // Doubled letter: cipher it with x and keep it for the next pair.
                  a_in = pending_letter_ff;
                  b_in = LetX;
               end else begin
                  a_in              = pending_letter_ff;
                  b_in              = lt.idx;
                  pending_valid_in  = 1'b0;
                  pending_letter_in = '0;
               end
            end
            KIND_TEXT_END: begin
               if (!table_ready_ff) begin
                  err_status_in = STAT_NO_TABLE;
               end else if (pending_valid_ff) begin
                  err_status_in     = STAT_ODD_LENGTH;
                  a_in              = pending_letter_ff;
                  b_in              = LetX;
                  pending_valid_in  = 1'b0;
                  pending_letter_in = '0;
               end
            end
            default: begin
            end
         endcase
      end
      if (csr_we) begin
         pending_valid_in  = 1'b0;
         pending_letter_in = '0;
      end
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         mode_ff           <= 1'b0;
         used_ff           <= '0;
         fill_count_ff     <= '0;
         table_ready_ff    <= 1'b0;
         pending_valid_ff  <= 1'b0;
         pending_letter_ff <= '0;
         fill_idx_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         used_ff           <= used_in;
         fill_count_ff     <= fill_count_in;
         table_ready_ff    <= table_ready_in;
         pending_valid_ff  <= pending_valid_in;
         pending_letter_ff <= pending_letter_in;
         fill_idx_ff       <= fill_idx_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      err_status_ff <= err_status_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   pfc_key_store u_key_store (
      .clock (clock),
      .wr    (ks_wr),
      .rd    (ks_rd),
      .pos_q (pos_q),
      .sq_q  (sq_q)
   );

   pfc_pair_calc u_pair_calc (
      .clock (clock),
      .ctrl  (pc_ctrl),
      .mode  (mode_ff),
      .pos_q (pos_q),
      .q1    (q1),
      .q2    (q2)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A finished table is always completely filled.
   a_table_full: assert property (@(posedge clock) disable iff (reset)
      (table_ready_ff && (state_ff == S_IDLE)) |-> (fill_count_ff == 5'(SqCells)))
      else $error("table ready with a partly filled square");

   // A pending letter only exists against a finished table.
   a_pending_needs_table: assert property (@(posedge clock) disable iff (reset)
      pending_valid_ff |-> table_ready_ff)
      else $error("pending letter without a table");

   // Once the first letter of a pair leaves, the second is being read or already waits.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_of_pair) |=>
      ((state_ff == S_OUT2) || (rsp_valid && rsp_data.last_of_pair)))
      else $error("first letter of a pair not followed by the second");

endmodule

`default_nettype wire
